// ===== src/lcx_pkg.sv =====
// Package for the horizontal line clipper: widths, codes and the item structs.
// No dependencies; every other file of the block depends on it.

package lcx_pkg;

    // Fixed-point fraction of the slope.
    localparam int FRAC_BITS = 8;

    // Coordinate, difference and magnitude widths.
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = COORD_W;
    localparam int NUM_W   = MAG_W + FRAC_BITS;
    localparam int PITCH_W = NUM_W + 1;
    localparam int PROD_W  = PITCH_W + DIFF_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLIP_LEFT  = 1'b0,
        REG_CLIP_RIGHT = 1'b1
    } cfg_reg_t;

    // Class of an endpoint against the clip range.
    typedef enum logic [1:0] {
        CLS_IN    = 2'd0,
        CLS_LEFT  = 2'd1,
        CLS_RIGHT = 2'd2
    } cls_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Segment data that travels alongside the divider.
    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        coord_t sx_edge;
        coord_t ex_edge;
        cls_t   cs;
        cls_t   ce;
        logic   rej;
        logic   dx_zero;
        logic   neg;
    } lcx_side_t;

    // One stage of the restoring divider.
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        logic [MAG_W-1:0] den;
    } lcx_div_t;

endpackage

// ===== src/lcx_ifs.sv =====
// Handshake interfaces of the line clipper: segment in, result out, register writes.
// Depends on lcx_pkg for the coordinate and index types.

interface lcx_seg_if;
    import lcx_pkg::*;
    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lcx_res_if;
    import lcx_pkg::*;
    logic   valid;
    logic   ready;
    coord_t out_start_x;
    coord_t out_start_y;
    coord_t out_end_x;
    coord_t out_end_y;
    logic   rejected;
    modport source (output valid, out_start_x, out_start_y, out_end_x, out_end_y, rejected,
                    input ready);
    modport sink (input valid, out_start_x, out_start_y, out_end_x, out_end_y, rejected,
                  output ready);
endinterface

interface lcx_cfg_if;
    import lcx_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    coord_t               data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/lcx_prep.sv =====
// First stage: classifies the endpoints, takes differences and sets up the divide.
// Depends on lcx_pkg.

module lcx_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  lcx_pkg::coord_t   sx,
    input  lcx_pkg::coord_t   sy,
    input  lcx_pkg::coord_t   ex,
    input  lcx_pkg::coord_t   ey,
    input  lcx_pkg::coord_t   clip_left,
    input  lcx_pkg::coord_t   clip_right,
    output logic              out_valid,
    output lcx_pkg::lcx_side_t side,
    output lcx_pkg::lcx_div_t  div
);
    import lcx_pkg::*;

    logic               valid_reg;
    lcx_side_t          side_reg, side_next;
    lcx_div_t           div_reg, div_next;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [DIFF_W-1:0]  dx_abs, dy_abs;

    function automatic cls_t classify(coord_t x, coord_t lo, coord_t hi);
        cls_t c;
        if (x < lo)
            c = CLS_LEFT;
        else if (x > hi)
            c = CLS_RIGHT;
        else
            c = CLS_IN;
        return c;
    endfunction

    // Classes, edges and the unsigned operands of the slope divide.
    always_comb
    begin
        dx = DIFF_W'(ex) - DIFF_W'(sx);
        dy = DIFF_W'(ey) - DIFF_W'(sy);
        dx_abs = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        dy_abs = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        side_next.sx = sx;
        side_next.sy = sy;
        side_next.ex = ex;
        side_next.ey = ey;
        side_next.cs = classify(sx, clip_left, clip_right);
        side_next.ce = classify(ex, clip_left, clip_right);
        side_next.sx_edge = (side_next.cs == CLS_LEFT) ? clip_left : clip_right;
        side_next.ex_edge = (side_next.ce == CLS_LEFT) ? clip_left : clip_right;
        side_next.rej = (side_next.cs == side_next.ce) && (side_next.cs != CLS_IN);
        side_next.dx_zero = (dx == '0);
        side_next.neg = dx[DIFF_W-1] ^ dy[DIFF_W-1];
        div_next.rem = '0;
        div_next.num = {dy_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
        div_next.quo = '0;
        div_next.den = dx_abs[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            div_reg  <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;
    assign div       = div_reg;

endmodule

// ===== src/lcx_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, side data carried along.
// Depends on lcx_pkg.

module lcx_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  lcx_pkg::lcx_side_t in_side,
    input  lcx_pkg::lcx_div_t  in_div,
    output logic               out_valid,
    output lcx_pkg::lcx_side_t out_side,
    output logic [lcx_pkg::NUM_W-1:0] quo
);
    import lcx_pkg::*;

    logic      valid_reg [NUM_W];
    lcx_side_t side_reg  [NUM_W];
    lcx_div_t  div_reg   [NUM_W];
    lcx_div_t  div_next  [NUM_W];

    // Each stage shifts in one numerator bit and tries a subtract.
    always_comb
    begin
        lcx_div_t       src;
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        for (int k = 0; k < NUM_W; k++)
        begin
            src = (k == 0) ? in_div : div_reg[k-1];
            trial = {src.rem, src.num[NUM_W-1]};
            diff = trial - {1'b0, src.den};
            div_next[k].den = src.den;
            div_next[k].num = {src.num[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, src.den})
            begin
                div_next[k].rem = diff[MAG_W-1:0];
                div_next[k].quo = {src.quo[NUM_W-2:0], 1'b1};
            end
            else
            begin
                div_next[k].rem = trial[MAG_W-1:0];
                div_next[k].quo = {src.quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_W; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < NUM_W; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 1; k < NUM_W; k++)
                side_reg[k] <= side_reg[k-1];
            for (int k = 0; k < NUM_W; k++)
                div_reg[k] <= div_next[k];
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];
    assign quo       = div_reg[NUM_W-1].quo;

endmodule

// ===== src/lcx_ycalc.sv =====
// Back end: signs the slope, recomputes the moved y values and holds the result item.
// Depends on lcx_pkg.

module lcx_ycalc (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  lcx_pkg::lcx_side_t in_side,
    input  logic [lcx_pkg::NUM_W-1:0] quo,
    output logic               out_valid,
    output lcx_pkg::coord_t    o_sx,
    output lcx_pkg::coord_t    o_sy,
    output lcx_pkg::coord_t    o_ex,
    output lcx_pkg::coord_t    o_ey,
    output logic               o_rej
);
    import lcx_pkg::*;

    logic [4:0] valid_reg;
    lcx_side_t  s1_reg, s2_reg, s3_reg, s4_reg;
    coord_t     sxn1_reg, sxn2_reg, sxn3_reg, sxn4_reg;
    coord_t     sy3_reg, sy4_reg;
    logic signed [PITCH_W-1:0] pitch1_reg, pitch2_reg, pitch3_reg;
    logic signed [DIFF_W-1:0]  dxs1_reg, dxe1_reg, dxe2_reg, dxe3_reg;
    logic signed [PROD_W-1:0]  prods2_reg, prode4_reg;
    coord_t     sy3_next, ey5_next;
    coord_t     o_sx_reg, o_sy_reg, o_ex_reg, o_ey_reg;
    logic       o_rej_reg;
    coord_t     sxn_next, exn4;
    logic signed [PITCH_W-1:0] pitch_next;

    // Stage one: signed slope and the two x spans from the moved start.
    always_comb
    begin
        sxn_next = (in_side.cs != CLS_IN) ? in_side.sx_edge : in_side.sx;
        if (in_side.dx_zero)
            pitch_next = '0;
        else if (in_side.neg)
            pitch_next = -$signed({1'b0, quo});
        else
            pitch_next = $signed({1'b0, quo});
    end

    // Stage three: moved start y; stage five: moved end y.
    always_comb
    begin
        sy3_next = (s2_reg.cs != CLS_IN)
                 ? coord_t'(s2_reg.ey - prods2_reg[FRAC_BITS +: COORD_W])
                 : s2_reg.sy;
        exn4 = (s4_reg.ce != CLS_IN) ? s4_reg.ex_edge : s4_reg.ex;
        ey5_next = (s4_reg.ce != CLS_IN)
                 ? coord_t'(sy4_reg + prode4_reg[FRAC_BITS +: COORD_W])
                 : s4_reg.ey;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg     <= in_side;
            sxn1_reg   <= sxn_next;
            pitch1_reg <= pitch_next;
            dxs1_reg   <= DIFF_W'(in_side.ex) - DIFF_W'(sxn_next);
            dxe1_reg   <= DIFF_W'((in_side.ce == CLS_IN) ? in_side.ex : in_side.ex_edge)
                        - DIFF_W'(sxn_next);

            s2_reg     <= s1_reg;
            sxn2_reg   <= sxn1_reg;
            pitch2_reg <= pitch1_reg;
            dxe2_reg   <= dxe1_reg;
            prods2_reg <= PROD_W'(pitch1_reg) * PROD_W'(dxs1_reg);

            s3_reg     <= s2_reg;
            sxn3_reg   <= sxn2_reg;
            pitch3_reg <= pitch2_reg;
            dxe3_reg   <= dxe2_reg;
            sy3_reg    <= sy3_next;

            s4_reg     <= s3_reg;
            sxn4_reg   <= sxn3_reg;
            sy4_reg    <= sy3_reg;
            prode4_reg <= PROD_W'(pitch3_reg) * PROD_W'(dxe3_reg);

            o_rej_reg  <= s4_reg.rej;
            o_sx_reg   <= s4_reg.rej ? '0 : sxn4_reg;
            o_sy_reg   <= s4_reg.rej ? '0 : sy4_reg;
            o_ex_reg   <= s4_reg.rej ? '0 : exn4;
            o_ey_reg   <= s4_reg.rej ? '0 : ey5_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign o_sx  = o_sx_reg;
    assign o_sy  = o_sy_reg;
    assign o_ex  = o_ex_reg;
    assign o_ey  = o_ey_reg;
    assign o_rej = o_rej_reg;

endmodule

// ===== src/line_clip_x_range_top.sv =====
// An accepted item passes through the prep register, the divider and the back end to its result.
// Throughput: one item per cycle while no result waits untaken; the divider has 24 stages.
// The whole pipeline advances together whenever the result register is empty or taken.
// Reset clears all valid bits and sets clip_left to 0 and clip_right to 32767.
// Depends on lcx_pkg, the interfaces in lcx_ifs, lcx_prep, lcx_div and lcx_ycalc.

module line_clip_x_range_top (
    input  logic      clk,
    input  logic      rst_n,
    lcx_cfg_if.sink   cfg,
    lcx_seg_if.sink   seg,
    lcx_res_if.source res
);
    import lcx_pkg::*;

    coord_t    clip_left_reg, clip_right_reg;
    logic      en;
    logic      p_valid, d_valid;
    lcx_side_t p_side, d_side;
    lcx_div_t  p_div;
    logic [NUM_W-1:0] d_quo;

    // Register writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg  <= '0;
            clip_right_reg <= 16'sh7FFF;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_CLIP_LEFT:  clip_left_reg  <= cfg.data;
                REG_CLIP_RIGHT: clip_right_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // Global advance: the result register is free or being taken.
    assign en = !res.valid || res.ready;
    assign seg.ready = en;

    lcx_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (seg.valid),
        .sx         (seg.start_x),
        .sy         (seg.start_y),
        .ex         (seg.end_x),
        .ey         (seg.end_y),
        .clip_left  (clip_left_reg),
        .clip_right (clip_right_reg),
        .out_valid  (p_valid),
        .side       (p_side),
        .div        (p_div)
    );

    lcx_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid),
        .in_side   (p_side),
        .in_div    (p_div),
        .out_valid (d_valid),
        .out_side  (d_side),
        .quo       (d_quo)
    );

    lcx_ycalc u_ycalc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .in_side   (d_side),
        .quo       (d_quo),
        .out_valid (res.valid),
        .o_sx      (res.out_start_x),
        .o_sy      (res.out_start_y),
        .o_ex      (res.out_end_x),
        .o_ey      (res.out_end_y),
        .o_rej     (res.rejected)
    );

endmodule

// ===== src/lcx_checker.sv =====
// Port-level checks for the line clipper, bound to the top level.
// Depends on lcx_pkg for the coordinate type.

module lcx_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input lcx_pkg::coord_t out_start_x,
    input lcx_pkg::coord_t out_start_y,
    input lcx_pkg::coord_t out_end_x,
    input lcx_pkg::coord_t out_end_y,
    input logic            rejected
);

    // A rejected item carries all-zero points.
    a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> out_start_x == '0 && out_start_y == '0 &&
                                  out_end_x == '0 && out_end_y == '0)
        else $error("rejected item with nonzero points");

    // The input side stalls exactly when a result waits untaken.
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    // A waiting result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // No result appears in the cycle after reset is released.
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid straight after reset");

endmodule

bind line_clip_x_range_top lcx_checker u_lcx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (seg.ready),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .out_start_x (res.out_start_x),
    .out_start_y (res.out_start_y),
    .out_end_x   (res.out_end_x),
    .out_end_y   (res.out_end_y),
    .rejected    (res.rejected)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the horizontal line clipper: directed table, then random segments.
// Depends on lcx_pkg, the interfaces in lcx_ifs and the top level line_clip_x_range_top.

`timescale 1ns / 100ps

module testbench;
    import lcx_pkg::*;

    // One segment and one clipped result.
    typedef struct {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } seg_t;

    typedef struct {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        logic   rej;
    } clip_t;

    // A row of the directed table: segment, optional typed expectation.
    typedef struct {
        seg_t  seg;
        bit    typed;
        clip_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lcx_cfg_if cfg ();
    lcx_seg_if seg ();
    lcx_res_if res ();

    line_clip_x_range_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .seg   (seg),
        .res   (res)
    );

    // Local copy of the clip range.
    logic signed [15:0] edge_left;
    logic signed [15:0] edge_right;

    clip_t clips_pending[$];
    int    n_fail = 0;
    int    n_seen = 0;
    bit    calm = 1'b0;
    int    sink_stall = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // Floor shift of a wide product by the slope fraction.
    function automatic longint floor_shift(longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic cls_t classify_x(longint x);
        if (x < longint'(edge_left))
            return CLS_LEFT;
        if (x > longint'(edge_right))
            return CLS_RIGHT;
        return CLS_IN;
    endfunction

    // Predicts the clipped segment from the current range.
    function automatic clip_t clip_segment(seg_t s);
        clip_t  r;
        cls_t   cs;
        cls_t   ce;
        longint sx, sy, ex, ey, dx, dy, pitch;
        sx = s.sx;
        sy = s.sy;
        ex = s.ex;
        ey = s.ey;
        cs = classify_x(sx);
        ce = classify_x(ex);
        r = '{default: '0};
        if (cs == ce && cs != CLS_IN)
        begin
            r.rej = 1'b1;
            return r;
        end
        dx = ex - sx;
        dy = ey - sy;
        // SystemVerilog division truncates toward zero, as required.
        pitch = (dx != 0) ? (dy * (64'sd1 <<< FRAC_BITS)) / dx : 0;
        if (cs != CLS_IN)
        begin
            sx = (cs == CLS_LEFT) ? longint'(edge_left) : longint'(edge_right);
            sy = longint'(coord_t'(ey - floor_shift(pitch * (ex - sx))));
        end
        if (ce != CLS_IN)
        begin
            ex = (ce == CLS_LEFT) ? longint'(edge_left) : longint'(edge_right);
            ey = longint'(coord_t'(sy + floor_shift(pitch * (ex - sx))));
        end
        r.sx = coord_t'(sx);
        r.sy = coord_t'(sy);
        r.ex = coord_t'(ex);
        r.ey = coord_t'(ey);
        r.rej = 1'b0;
        return r;
    endfunction

    // Result side: random stalls, compares each item with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            sink_stall <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                clip_t w;
                n_seen <= n_seen + 1;
                if (clips_pending.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    n_fail++;
                end
                else
                begin
                    w = clips_pending.pop_front();
                    if (res.out_start_x !== w.sx)
                    begin
                        $error("out_start_x expected %0d actual %0d", w.sx, res.out_start_x);
                        n_fail++;
                    end
                    if (res.out_start_y !== w.sy)
                    begin
                        $error("out_start_y expected %0d actual %0d", w.sy, res.out_start_y);
                        n_fail++;
                    end
                    if (res.out_end_x !== w.ex)
                    begin
                        $error("out_end_x expected %0d actual %0d", w.ex, res.out_end_x);
                        n_fail++;
                    end
                    if (res.out_end_y !== w.ey)
                    begin
                        $error("out_end_y expected %0d actual %0d", w.ey, res.out_end_y);
                        n_fail++;
                    end
                    if (res.rejected !== w.rej)
                    begin
                        $error("rejected expected %0d actual %0d", w.rej, res.rejected);
                        n_fail++;
                    end
                end
            end
            // Stall at random, none in the calm stretch.
            if (sink_stall > 0)
            begin
                sink_stall <= sink_stall - 1;
                res.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                sink_stall <= $urandom_range(0, 18);
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    // Writes one clip register and mirrors it locally; valid drops afterwards.
    task automatic write_reg(cfg_reg_t idx, logic signed [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_CLIP_LEFT)
            edge_left = val;
        else
            edge_right = val;
        @(posedge clk);
    endtask

    // Sends one segment, with a random gap before it unless calm.
    task automatic send_segment(seg_t s, bit typed, clip_t want);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            seg.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg.valid <= 1'b1;
        seg.start_x <= s.sx;
        seg.start_y <= s.sy;
        seg.end_x <= s.ex;
        seg.end_y <= s.ey;
        do
            @(posedge clk);
        while (!seg.ready);
        clips_pending.push_back(typed ? want : clip_segment(s));
    endtask

    // Waits until every expectation has been met, then lets the pipeline drain.
    task automatic drain();
        seg.valid <= 1'b0;
        while (clips_pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic coord_t rand_coord();
        return coord_t'($urandom());
    endfunction

    // Random coordinate biased towards the two clip edges.
    function automatic coord_t near_edge();
        case ($urandom_range(0, 3))
            0: return coord_t'(edge_left + $signed($urandom_range(0, 8)) - 4);
            1: return coord_t'(edge_right + $signed($urandom_range(0, 8)) - 4);
            default: return rand_coord();
        endcase
    endfunction

    initial
    begin
        row_t   rows[$];
        clip_t  zero_rej;
        clip_t  none;
        seg_t   s;
        int     phase;
        logic signed [15:0] a, b;

        cfg.valid = 1'b0;
        cfg.index = REG_CLIP_LEFT;
        cfg.data = '0;
        seg.valid = 1'b0;
        seg.start_x = '0;
        seg.start_y = '0;
        seg.end_x = '0;
        seg.end_y = '0;
        edge_left = 16'sd0;
        edge_right = 16'sd32767;
        zero_rej = '{sx: 0, sy: 0, ex: 0, ey: 0, rej: 1'b1};
        none = '{default: '0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under the reset range [0, 32767].
        rows.push_back('{'{-16'sd5, 16'sd3, -16'sd1, 16'sd9}, 1'b1, zero_rej});
        rows.push_back('{'{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767}, 1'b1, zero_rej});
        rows.push_back('{'{16'sd10, 16'sd20, 16'sd30, 16'sd40}, 1'b1,
                         '{sx: 16'sd10, sy: 16'sd20, ex: 16'sd30, ey: 16'sd40, rej: 1'b0}});
        rows.push_back('{'{16'sd0, -16'sd32768, 16'sd32767, 16'sd32767}, 1'b1,
                         '{sx: 16'sd0, sy: -16'sd32768, ex: 16'sd32767, ey: 16'sd32767,
                           rej: 1'b0}});
        rows.push_back('{'{-16'sd100, 16'sd0, 16'sd100, 16'sd200}, 1'b0, none});
        rows.push_back('{'{16'sd100, 16'sd50, -16'sd100, -16'sd50}, 1'b0, none});
        rows.push_back('{'{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768}, 1'b0, none});
        rows.push_back('{'{16'sd5, 16'sd1, 16'sd5, 16'sd7}, 1'b0, none});
        rows.push_back('{'{-16'sd1, -16'sd32768, 16'sd1, 16'sd32767}, 1'b0, none});
        foreach (rows[i])
            send_segment(rows[i].seg, rows[i].typed, rows[i].want);
        drain();

        // Narrow range: spanning segments, vertical and wholly right ones.
        write_reg(REG_CLIP_LEFT, -16'sd50);
        write_reg(REG_CLIP_RIGHT, 16'sd50);
        rows.delete();
        rows.push_back('{'{16'sd60, 16'sd1, 16'sd70, 16'sd2}, 1'b1, zero_rej});
        rows.push_back('{'{-16'sd200, -16'sd300, 16'sd200, 16'sd300}, 1'b0, none});
        rows.push_back('{'{16'sd300, 16'sd7, -16'sd300, -16'sd9}, 1'b0, none});
        rows.push_back('{'{16'sd20, 16'sd1, 16'sd20, 16'sd900}, 1'b0, none});
        rows.push_back('{'{-16'sd32768, 16'sd32767, 16'sd0, -16'sd32768}, 1'b0, none});
        rows.push_back('{'{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767}, 1'b0, none});
        foreach (rows[i])
            send_segment(rows[i].seg, rows[i].typed, rows[i].want);
        drain();

        // Crossed edges: left greater than right.
        write_reg(REG_CLIP_LEFT, 16'sd40);
        write_reg(REG_CLIP_RIGHT, -16'sd40);
        rows.delete();
        rows.push_back('{'{16'sd0, 16'sd5, 16'sd10, 16'sd9}, 1'b0, none});
        rows.push_back('{'{-16'sd100, 16'sd5, 16'sd100, -16'sd9}, 1'b0, none});
        rows.push_back('{'{16'sd100, 16'sd3, 16'sd200, 16'sd4}, 1'b0, none});
        foreach (rows[i])
            send_segment(rows[i].seg, rows[i].typed, rows[i].want);
        drain();

        // Random phases over several ranges, the extremes among them.
        for (phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: begin a = -16'sd32768; b = 16'sd32767; end
                1: begin a = 16'sd32767; b = -16'sd32768; end
                2: begin a = -16'sd32768; b = -16'sd32768; end
                3: begin a = 16'sd32767; b = 16'sd32767; end
                default:
                begin
                    a = $signed(16'($urandom()));
                    b = $signed(16'($urandom()));
                    if (phase < 7 && a > b)
                    begin
                        a = a ^ b;
                        b = a ^ b;
                        a = a ^ b;
                    end
                end
            endcase
            write_reg(REG_CLIP_LEFT, a);
            write_reg(REG_CLIP_RIGHT, b);
            calm = (phase == 8);
            repeat (150)
            begin
                if ($urandom_range(0, 3) == 0)
                    s = '{rand_coord(), rand_coord(), rand_coord(), rand_coord()};
                else
                    s = '{near_edge(), rand_coord(), near_edge(), rand_coord()};
                send_segment(s, 1'b0, none);
            end
            drain();
        end

        if (n_fail == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/lcx_pkg.sv
src/lcx_ifs.sv
src/lcx_prep.sv
src/lcx_div.sv
src/lcx_ycalc.sv
src/line_clip_x_range_top.sv
src/lcx_checker.sv
dv/testbench.sv
